@@ design/sitda_pkg.sv @@
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared types, character codes and sizing helpers for the signed integer
// to decimal text converter.
// ----------------------------------------------------------------------------
package sitda_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int CHAR_W          = 6;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

  // Decimal digits needed for a w-bit unsigned magnitude:
  // floor(w * log10(2)) + 1, with log10(2) ~ 1233 / 4096.
  function automatic int ndigits(input int w);
    ndigits = ((w * 1233) >> 12) + 1;
  endfunction

  // Datapath commands from the controller.
  typedef struct packed {
    logic load;       // capture sign and magnitude, clear BCD
    logic step;       // one double-dabble shift step
    logic shift;      // drop the top BCD digit
    logic out_load;   // write the output character register
    logic out_minus;  // character is '-' instead of the top digit
    logic out_last;   // final character of the text
  } cmd_t;

  // Datapath status to the controller.
  typedef struct packed {
    logic       neg;
    logic [3:0] top_digit;
  } sts_t;

endpackage

@@ design/sitda_dp.sv @@
// ----------------------------------------------------------------------------
// sitda_dp
// Datapath: magnitude shift register, BCD register with add-3 correction,
// and the output character register.
// ----------------------------------------------------------------------------
module sitda_dp #(
  parameter int VALUE_WIDTH = sitda_pkg::VALUE_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic signed [VALUE_WIDTH-1:0]    in_value,
  input  sitda_pkg::cmd_t                  cmd,
  output sitda_pkg::sts_t                  sts,
  output logic [sitda_pkg::CHAR_W-1:0]     out_character,
  output logic                             out_last
);
  import sitda_pkg::*;

  localparam int NDIG = ndigits(VALUE_WIDTH);
  localparam int BW   = 4 * NDIG;

  logic                   neg_r;
  logic [VALUE_WIDTH-1:0] mag_r;
  logic [BW-1:0]          bcd_r;
  logic [BW-1:0]          bcd_adj;
  logic [CHAR_W-1:0]      char_r;
  logic                   last_r;
  logic [CHAR_W-1:0]      char_nxt;

  // add-3 on every digit that is 5 or more, ahead of the shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  assign char_nxt = cmd.out_minus ? CHAR_MINUS
                                  : CHAR_ZERO + {{(CHAR_W-4){1'b0}}, bcd_r[BW-1 -: 4]};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg_r <= in_value[VALUE_WIDTH-1];
      // wraps to 2^(W-1) for the most negative value, which is the right magnitude
      mag_r <= in_value[VALUE_WIDTH-1] ? (~in_value + 1'b1) : in_value;
      bcd_r <= '0;
    end else if (cmd.step) begin
      mag_r <= {mag_r[VALUE_WIDTH-2:0], 1'b0};
      bcd_r <= {bcd_adj[BW-2:0], mag_r[VALUE_WIDTH-1]};
    end else if (cmd.shift) begin
      bcd_r <= {bcd_r[BW-5:0], 4'd0};
    end
    if (cmd.out_load) begin
      char_r <= char_nxt;
      last_r <= cmd.out_last;
    end
  end

  assign sts.neg       = neg_r;
  assign sts.top_digit = bcd_r[BW-1 -: 4];
  assign out_character = char_r;
  assign out_last      = last_r;

endmodule

@@ design/sitda_ctrl.sv @@
// ----------------------------------------------------------------------------
// sitda_ctrl
// Controller: sequences the conversion steps, the sign and the digit
// emission with leading-zero suppression, and owns both handshakes.
// ----------------------------------------------------------------------------
module sitda_ctrl #(
  parameter int VALUE_WIDTH = sitda_pkg::VALUE_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  sitda_pkg::sts_t sts,
  output sitda_pkg::cmd_t cmd
);
  import sitda_pkg::*;

  localparam int NDIG = ndigits(VALUE_WIDTH);
  localparam int CW   = $clog2(VALUE_WIDTH);
  localparam int DW   = $clog2(NDIG);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_EMIT
  } state_t;

  state_t          state_r;
  logic [CW-1:0]   step_cnt_r;
  logic [DW-1:0]   dig_cnt_r;
  logic            started_r;
  logic            out_valid_r;

  logic            out_free;
  logic            dig_last;
  logic            dig_show;
  logic            accept;

  assign out_free = !out_valid_r || out_ready;
  assign dig_last = (dig_cnt_r == DW'(NDIG - 1));
  assign dig_show = started_r || dig_last || (sts.top_digit != 4'd0);
  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.load = accept;
      end
      ST_CONV: begin
        cmd.step = 1'b1;
      end
      ST_SIGN: begin
        cmd.out_load  = out_free;
        cmd.out_minus = 1'b1;
      end
      ST_EMIT: begin
        // a suppressed leading zero just shifts out without a request
        cmd.out_load = dig_show && out_free;
        cmd.out_last = dig_last;
        cmd.shift    = !dig_show || out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_cnt_r  <= '0;
      dig_cnt_r   <= '0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r    <= ST_CONV;
            step_cnt_r <= '0;
          end
        end
        ST_CONV: begin
          step_cnt_r <= step_cnt_r + 1'b1;
          dig_cnt_r  <= '0;
          started_r  <= 1'b0;
          if (step_cnt_r == CW'(VALUE_WIDTH - 1)) begin
            state_r <= sts.neg ? ST_SIGN : ST_EMIT;
          end
        end
        ST_SIGN: begin
          if (out_free) begin
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (cmd.shift) begin
            dig_cnt_r <= dig_cnt_r + 1'b1;
            if (cmd.out_load) begin
              started_r <= 1'b1;
            end
            if (dig_last) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  a_accept_starts_conv: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_CONV))
    else $error("accepted request did not start conversion");

  a_last_ends_text: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && cmd.shift && dig_last) |-> (cmd.out_load && cmd.out_last))
    else $error("text ended without a last character");

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && cmd.out_last) |=> (state_r == ST_IDLE))
    else $error("last character not followed by idle");

  a_no_load_over_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !cmd.out_load)
    else $error("output register overwritten while pending");

  a_dig_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (dig_cnt_r <= DW'(NDIG - 1)))
    else $error("digit counter out of range");

endmodule

@@ design/signed_int_to_decimal_ascii.sv @@
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Renders a signed two's complement integer as decimal ASCII text, one
// character per output request, most significant first.
// ----------------------------------------------------------------------------
// Each request carries one VALUE_WIDTH-bit signed integer. The block answers
// with its decimal text: an optional '-', then the digits with leading zeros
// dropped (zero gives a single '0'); out_last marks the final character. The
// most negative value prints correctly. Conversion is a double-dabble
// binary-to-BCD loop of VALUE_WIDTH shift steps, one per cycle, after which
// the controller emits a '-' when negative and then walks all
// floor(VALUE_WIDTH*log10(2)) + 1 digit positions, one per cycle while the
// output is not stalled. One item is in flight at a time; the next is taken
// while the final character still waits in the output register.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii #(
  parameter int VALUE_WIDTH = sitda_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sitda_pkg::CHAR_W-1:0]  out_character,
  output logic                          out_last
);
  import sitda_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sitda_ctrl #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sitda_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk           (clk),
    .in_value      (in_value),
    .cmd           (cmd),
    .sts           (sts),
    .out_character (out_character),
    .out_last      (out_last)
  );

endmodule
